@@ rtl/eeit_pkg.sv @@
// Package: shared types and constants of the epoch extent index table.
package eeit_pkg;

    localparam int ENTRIES     = 64;
    localparam int EPOCH_SLOTS = 8;
    localparam int EW          = $clog2(ENTRIES);
    localparam int SW          = $clog2(EPOCH_SLOTS);
    localparam int CW          = EW + 1;

    localparam logic [1:0] REG_CACHING = 2'd0;

    typedef enum logic [1:0] {
        OP_PUT      = 2'd0,
        OP_LOOKUP   = 2'd1,
        OP_TRUNCATE = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISS       = 3'd1,
        ST_DISABLED   = 3'd2,
        ST_EXT_FULL   = 3'd3,
        ST_EPOCH_FULL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_OUT
    } t_state;

    // Per-entry compare result from the shared compare unit.
    typedef struct packed {
        logic key_match;
        logic contains;
        logic lower;
        logic older;
    } t_cmp;

endpackage

@@ rtl/eeit_cmp.sv @@
// Shared compare unit: matches one stored entry against the current transaction.
module eeit_cmp (
    input  logic [31:0]      i_epoch,
    input  logic [63:0]      i_object,
    input  logic [47:0]      i_start,
    input  logic [31:0]      i_length,
    input  logic [31:0]      i_ent_epoch,
    input  logic [63:0]      i_ent_object,
    input  logic [47:0]      i_ent_start,
    input  logic [31:0]      i_ent_length,
    input  logic [47:0]      i_best_start,
    output eeit_pkg::t_cmp   o_cmp
);
    import eeit_pkg::*;

    logic [48:0] qend;
    logic [48:0] cend;

    always_comb begin
        qend = {1'b0, i_start} + {17'd0, i_length};
        cend = {1'b0, i_ent_start} + {17'd0, i_ent_length};
        o_cmp.key_match = (i_ent_epoch == i_epoch) && (i_ent_object == i_object);
        o_cmp.contains  = (i_start >= i_ent_start) && (qend <= cend);
        o_cmp.lower     = i_ent_start < i_best_start;
        o_cmp.older     = i_ent_epoch < i_epoch;
    end

endmodule

@@ rtl/epoch_extent_index_table.sv @@
// Top level: epoch extent index table with a sequential scan over one entry memory.
// Each transaction scans all 64 entries through one shared compare unit, with a registered
// memory read ahead of each compare, then passes through the decide, write and output
// states, after which o_valid rises. The next transaction is accepted only after the result
// is taken; the block is not ready while a transaction is in progress or its result waits.
// No clearing pass is needed after reset.
module epoch_extent_index_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_epoch_number,
    input  logic [63:0] i_object_name,
    input  logic [47:0] i_byte_start,
    input  logic [31:0] i_byte_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_synthetic_offset,
    output logic [31:0] o_offset_in_extent,
    output logic [47:0] o_found_start,
    output logic [31:0] o_found_length,
    output logic [6:0]  o_entries_in_use
);
    import eeit_pkg::*;

    typedef struct packed {
        logic [31:0] epoch;
        logic [63:0] object;
        logic [47:0] start;
        logic [31:0] length;
        logic [63:0] offset;
    } t_entry;

    t_entry r_mem [ENTRIES];
    t_entry r_rd;

    logic [ENTRIES-1:0]     r_ent_valid;
    logic [EPOCH_SLOTS-1:0] r_ep_valid;
    logic [31:0]            r_ep_value [EPOCH_SLOTS];
    logic [63:0]            r_ep_cnt   [EPOCH_SLOTS];
    logic                   r_caching;

    t_state      r_state, n_state;
    logic [EW:0] r_idx;
    logic [EW-1:0] r_rd_idx;
    logic        r_rd_live;
    logic [1:0]  r_op;
    logic [31:0] r_epoch;
    logic [63:0] r_object;
    logic [47:0] r_start;
    logic [31:0] r_length;
    logic        r_hit;
    t_entry      r_best;
    logic [CW-1:0] r_count;
    logic        r_o_valid;
    logic [2:0]  r_status;
    logic [63:0] r_soff;
    logic [31:0] r_oie;
    logic [47:0] r_fstart;
    logic [31:0] r_flen;
    logic [EW-1:0] r_wr_idx;
    logic [SW-1:0] r_wr_slot;
    logic        r_new_slot;

    t_cmp        cmp;
    logic        slot_hit;
    logic [SW-1:0] slot_idx;
    logic        slot_free;
    logic [SW-1:0] free_slot;
    logic        ent_free;
    logic [EW-1:0] free_ent;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_caching};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caching <= 1'b1;
        end else if (psel && penable && pwrite && paddr == REG_CACHING) begin
            r_caching <= pwdata[0];
        end
    end

    eeit_cmp u_cmp (
        .i_epoch      (r_epoch),
        .i_object     (r_object),
        .i_start      (r_start),
        .i_length     (r_length),
        .i_ent_epoch  (r_rd.epoch),
        .i_ent_object (r_rd.object),
        .i_ent_start  (r_rd.start),
        .i_ent_length (r_rd.length),
        .i_best_start (r_best.start),
        .o_cmp        (cmp)
    );

    always_comb begin
        slot_hit  = 1'b0;
        slot_idx  = '0;
        slot_free = 1'b0;
        free_slot = '0;
        for (int s = EPOCH_SLOTS - 1; s >= 0; s--) begin
            if (r_ep_valid[s] && r_ep_value[s] == r_epoch) begin
                slot_hit = 1'b1;
                slot_idx = SW'(s);
            end
            if (!r_ep_valid[s]) begin
                slot_free = 1'b1;
                free_slot = SW'(s);
            end
        end
        ent_free = 1'b0;
        free_ent = '0;
        for (int e = ENTRIES - 1; e >= 0; e--) begin
            if (!r_ent_valid[e]) begin
                ent_free = 1'b1;
                free_ent = EW'(e);
            end
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid && o_ready) n_state = S_SCAN;
            S_SCAN:   if (r_idx == (EW+1)'(ENTRIES)) n_state = S_DECIDE;
            S_DECIDE: n_state = S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_op == OP_PUT && !r_hit && r_status == ST_OK) begin
            r_mem[r_wr_idx] <= '{epoch: r_epoch, object: r_object, start: r_start,
                                 length: r_length, offset: r_soff};
        end
        r_rd     <= r_mem[r_idx[EW-1:0]];
        r_rd_idx <= r_idx[EW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_ep_valid  <= '0;
            r_o_valid   <= 1'b0;
            r_rd_live   <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
        end else begin
            if (r_o_valid && i_ready) r_o_valid <= 1'b0;
            r_rd_live <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op     <= i_opcode;
                        r_epoch  <= i_epoch_number;
                        r_object <= i_object_name;
                        r_start  <= i_byte_start;
                        r_length <= i_byte_length;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_best   <= '0;
                        r_count  <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_idx != (EW+1)'(ENTRIES)) begin
                        r_idx     <= r_idx + 1'b1;
                        r_rd_live <= 1'b1;
                    end
                    if (r_rd_live && r_ent_valid[r_rd_idx]) begin
                        case (r_op)
                            OP_PUT: begin
                                if (!r_hit && cmp.key_match && r_rd.start == r_start) begin
                                    r_hit     <= 1'b1;
                                    r_best    <= r_rd;
                                end
                            end
                            OP_LOOKUP: begin
                                if (cmp.key_match && cmp.contains && (!r_hit || cmp.lower)) begin
                                    r_hit  <= 1'b1;
                                    r_best <= r_rd;
                                end
                            end
                            OP_TRUNCATE: begin
                                if (cmp.older) r_ent_valid[r_rd_idx] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DECIDE: begin
                    r_status   <= ST_OK;
                    r_soff     <= '0;
                    r_oie      <= '0;
                    r_fstart   <= '0;
                    r_flen     <= '0;
                    r_new_slot <= 1'b0;
                    r_wr_idx   <= free_ent;
                    r_wr_slot  <= slot_hit ? slot_idx : free_slot;
                    case (r_op)
                        OP_PUT: begin
                            if (r_hit && slot_hit) begin
                                r_soff <= r_best.offset;
                            end else if (!slot_hit && !r_caching) begin
                                r_status <= ST_DISABLED;
                            end else if (!slot_hit && !slot_free) begin
                                r_status <= ST_EPOCH_FULL;
                            end else if (!ent_free) begin
                                r_status <= ST_EXT_FULL;
                            end else begin
                                r_new_slot <= !slot_hit;
                                r_soff <= slot_hit ? r_ep_cnt[slot_idx] : 64'd0;
                            end
                            if (!slot_hit) r_hit <= 1'b0;
                        end
                        OP_LOOKUP: begin
                            if (r_hit) begin
                                r_soff   <= r_best.offset;
                                r_oie    <= 32'(r_start - r_best.start);
                                r_fstart <= r_best.start;
                                r_flen   <= r_best.length;
                            end else begin
                                r_status <= ST_MISS;
                            end
                        end
                        OP_TRUNCATE: begin
                            for (int s = 0; s < EPOCH_SLOTS; s++)
                                if (r_ep_value[s] < r_epoch) r_ep_valid[s] <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_WRITE: begin
                    if (r_op == OP_PUT && !r_hit && r_status == ST_OK) begin
                        r_ent_valid[r_wr_idx] <= 1'b1;
                        r_ep_cnt[r_wr_slot]   <= r_soff + 64'd1;
                        if (r_new_slot) begin
                            r_ep_valid[r_wr_slot] <= 1'b1;
                            r_ep_value[r_wr_slot] <= r_epoch;
                        end
                    end
                    r_idx <= '0;
                end
                S_OUT: begin
                    r_o_valid <= 1'b1;
                    r_count   <= CW'($countones(r_ent_valid));
                end
                default: ;
            endcase
        end
    end

    assign o_valid            = r_o_valid;
    assign o_status           = r_status;
    assign o_synthetic_offset = r_soff;
    assign o_offset_in_extent = r_oie;
    assign o_found_start      = r_fstart;
    assign o_found_length     = r_flen;
    assign o_entries_in_use   = 7'(r_count);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_OUT) else $error("result without sequence");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_count <= CW'(ENTRIES)) else $error("count overflow");

endmodule
